>>> hdl/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

  // Defaults for the top-level parameters
  localparam int ADC_BITS_DEF   = 12;
  localparam int ACCUM_BITS_DEF = 32;

  // Fixed field and intermediate widths
  localparam int TEMP_W   = 17;
  localparam int ERR_W    = 18;
  localparam int P_W      = 35;
  localparam int D_W      = 43;
  localparam int MAG_W    = 48;
  localparam int HALF_W   = 24;
  localparam int PART_W   = 48;
  localparam int PROD_W   = 72;
  localparam int I_W      = 60;
  localparam int SUM_W    = 61;
  localparam int X5_W     = 63;
  localparam int QUOT_SH  = 25;
  localparam int QUOT_W   = X5_W - QUOT_SH;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // 500 degrees full scale in Q.8
  localparam logic [TEMP_W-1:0] TEMP_SCALE = 17'd128000;
  localparam logic [PROD_W-1:0] I_LIMIT    = PROD_W'(1) << 58;

  // Register reset values
  localparam logic [15:0]       TARGET_RST = 16'd5120;
  localparam logic [15:0]       PROP_RST   = 16'd256;
  localparam logic [23:0]       INTEG_RST  = 24'd1;
  localparam logic [23:0]       DERIV_RST  = 24'd65535;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 8'd250;
  localparam logic [DUTY_W-1:0] DUTY_RST   = 8'd131;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_PROP   = 3'd1,
    REG_INTEG  = 3'd2,
    REG_DERIV  = 3'd3,
    REG_DMAX   = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEMP,
    ST_ERR,
    ST_MUL,
    ST_MAG,
    ST_ILO,
    ST_IHI,
    ST_ISAT,
    ST_SUM,
    ST_ABS,
    ST_QUOT,
    ST_DUTY
  } state_t;

  // Datapath load strobes
  typedef struct packed {
    logic ld_adc;
    logic ld_temp;
    logic ld_err;
    logic ld_mul;
    logic ld_mag;
    logic ld_ilo;
    logic ld_ihi;
    logic ld_isat;
    logic ld_sum;
    logic ld_abs;
    logic ld_quot;
    logic commit;
  } pfd_cmd_t;

  typedef struct packed {
    logic out_free;
  } pfd_status_t;

endpackage

>>> hdl/pid_fan_duty_controller_top.sv
`timescale 1ns / 1ps
// PID fan duty controller.
// Input channel: in_valid / in_ready with in_adc_sample, one raw sensor
// converter reading per request. Output channel: out_valid / out_ready with
// out_duty_value (clamped PWM compare value) and out_temp_q8 (temperature,
// unsigned Q9.8 degrees). Every request gives exactly one result.
// Configuration: cfg_we, cfg_index, cfg_wdata write one register per cycle
// (0 target, 1 proportional gain, 2 integral gain, 3 derivative gain,
// 4 duty ceiling); write only while no request is in flight.
// The sequencer steps one load per cycle through temperature, error, P/D
// products, accumulator magnitude, the two halves of the integral product,
// saturation, sum, magnitude, scaling and the duty update; it holds at the
// duty update while the output register is busy.
// in_ready is high only while the sequencer idles; a new request may be
// taken while a result still waits in the output register.
// If the receiver stalls, the result holds and the next request stops at its
// final step until the output register is free.
// Reset clears the error accumulator and previous temperature, sets the duty
// to 131, loads register defaults and drops out_valid.
module pid_fan_duty_controller_top #(
  parameter int ADC_BITS   = pfd_pkg::ADC_BITS_DEF,
  parameter int ACCUM_BITS = pfd_pkg::ACCUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ADC_BITS-1:0]            in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pfd_pkg::DUTY_W-1:0]     out_duty_value,
  output logic [pfd_pkg::TEMP_W-1:0]     out_temp_q8,
  input  logic                           cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfd_pkg::*;

  pfd_cmd_t    cmd;
  pfd_status_t status;

  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfd_datapath #(
    .ADC_BITS   (ADC_BITS),
    .ACCUM_BITS (ACCUM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_adc_sample  (in_adc_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_value (out_duty_value),
    .out_temp_q8    (out_temp_q8)
  );

endmodule

>>> hdl/pfd_ctrl.sv
`timescale 1ns / 1ps

module pfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfd_pkg::pfd_status_t status,
  output pfd_pkg::pfd_cmd_t    cmd
);
  import pfd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Step through the sequence, one load per state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_adc = 1'b1;
          state_nxt  = ST_TEMP;
        end
      end
      ST_TEMP: begin
        cmd.ld_temp = 1'b1;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.ld_mul = 1'b1;
        state_nxt  = ST_MAG;
      end
      ST_MAG: begin
        cmd.ld_mag = 1'b1;
        state_nxt  = ST_ILO;
      end
      ST_ILO: begin
        cmd.ld_ilo = 1'b1;
        state_nxt  = ST_IHI;
      end
      ST_IHI: begin
        cmd.ld_ihi = 1'b1;
        state_nxt  = ST_ISAT;
      end
      ST_ISAT: begin
        cmd.ld_isat = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = ST_ABS;
      end
      ST_ABS: begin
        cmd.ld_abs = 1'b1;
        state_nxt  = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.ld_quot = 1'b1;
        state_nxt   = ST_DUTY;
      end
      ST_DUTY: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/pfd_datapath.sv
`timescale 1ns / 1ps

module pfd_datapath #(
  parameter int ADC_BITS   = pfd_pkg::ADC_BITS_DEF,
  parameter int ACCUM_BITS = pfd_pkg::ACCUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfd_pkg::pfd_cmd_t                   cmd,
  output pfd_pkg::pfd_status_t                status,
  input  logic [ADC_BITS-1:0]                 in_adc_sample,
  input  logic                                cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pfd_pkg::DUTY_W-1:0]          out_duty_value,
  output logic [pfd_pkg::TEMP_W-1:0]          out_temp_q8
);
  import pfd_pkg::*;

  localparam int ACC_SUM_W = ((ACCUM_BITS > ERR_W) ? ACCUM_BITS : ERR_W) + 1;
  localparam int TMUL_W    = ADC_BITS + TEMP_W;
  localparam logic signed [ACC_SUM_W-1:0] ACC_HI =
    $signed({{(ACC_SUM_W-ACCUM_BITS+1){1'b0}}, {(ACCUM_BITS-1){1'b1}}});
  localparam logic signed [ACC_SUM_W-1:0] ACC_LO = ~ACC_HI;

  // Configuration registers
  logic [15:0]        target_r, prop_r;
  logic [23:0]        integ_r, deriv_r;
  logic [DUTY_W-1:0]  dmax_r;

  // Controller state
  logic [TEMP_W-1:0]          prev_r;
  logic signed [ACCUM_BITS-1:0] acc_r, acc_nxt;
  logic [DUTY_W-1:0]          duty_r, duty_nxt;

  // Working registers
  logic [ADC_BITS-1:0]     adc_r;
  logic [TEMP_W-1:0]       temp_r, temp_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt, dtemp_r, dtemp_nxt;
  logic signed [P_W-1:0]   p_r, p_nxt;
  logic signed [D_W-1:0]   d_r, d_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    acc_neg_r;
  logic [PART_W-1:0]       ilo_r, ilo_nxt, ihi_r, ihi_nxt;
  logic signed [I_W-1:0]   i_r, i_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]        smag_r, smag_nxt;
  logic                    sum_neg_r;
  logic [QUOT_W-1:0]       quot_r, quot_nxt;

  // Output register
  logic                    out_valid_r;
  logic [DUTY_W-1:0]       out_duty_r;
  logic [TEMP_W-1:0]       out_temp_r;

  logic [TMUL_W-1:0]               tmul;
  logic signed [ACC_SUM_W-1:0]     acc_sum;
  logic signed [MAG_W:0]           acc_wide;
  logic [PROD_W-1:0]               prod;
  logic [I_W-1:0]                  imag;
  logic [X5_W-1:0]                 x5;
  logic [QUOT_W:0]                 dsum;
  logic [DUTY_W-1:0]               dclamp;

  // Arithmetic for each step
  always_comb begin
    tmul      = TMUL_W'(adc_r) * TMUL_W'(TEMP_SCALE);
    temp_nxt  = tmul[TMUL_W-1:ADC_BITS];

    err_nxt   = $signed({1'b0, temp_r}) - $signed({2'b00, target_r});
    dtemp_nxt = $signed({1'b0, temp_r}) - $signed({1'b0, prev_r});

    p_nxt     = $signed({1'b0, prop_r}) * err_r;
    d_nxt     = $signed({1'b0, deriv_r}) * dtemp_r;
    acc_sum   = ACC_SUM_W'(acc_r) + ACC_SUM_W'(err_r);
    if (acc_sum > ACC_HI) begin
      acc_nxt = ACCUM_BITS'(ACC_HI);
    end else if (acc_sum < ACC_LO) begin
      acc_nxt = ACCUM_BITS'(ACC_LO);
    end else begin
      acc_nxt = ACCUM_BITS'(acc_sum);
    end

    acc_wide  = (MAG_W+1)'(acc_r);
    if (acc_r[ACCUM_BITS-1]) begin
      acc_wide = -acc_wide;
    end
    mag_nxt   = acc_wide[MAG_W-1:0];

    // Integral product in two halves
    ilo_nxt   = mag_r[HALF_W-1:0] * integ_r;
    ihi_nxt   = mag_r[MAG_W-1:HALF_W] * integ_r;
    prod      = {ihi_r, {HALF_W{1'b0}}} + PROD_W'(ilo_r);
    imag      = (prod > I_LIMIT) ? I_LIMIT[I_W-1:0] : prod[I_W-1:0];
    i_nxt     = acc_neg_r ? -$signed(imag) : $signed(imag);

    sum_nxt   = (SUM_W'(p_r) <<< 8) + SUM_W'(i_r) + (SUM_W'(d_r) <<< 8);
    smag_nxt  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

    // Times five over 2^25, truncated
    x5        = {smag_r, 2'b00} + X5_W'(smag_r);
    quot_nxt  = x5[X5_W-1:QUOT_SH];

    // Apply the step to the stored duty and clamp
    if (sum_neg_r) begin
      dsum = '0;
      if (quot_r >= QUOT_W'(duty_r)) begin
        dclamp = '0;
      end else begin
        dclamp = duty_r - quot_r[DUTY_W-1:0];
      end
    end else begin
      dsum = (QUOT_W+1)'(duty_r) + (QUOT_W+1)'(quot_r);
      if (dsum > (QUOT_W+1)'(dmax_r)) begin
        dclamp = dmax_r;
      end else begin
        dclamp = dsum[DUTY_W-1:0];
      end
    end
    duty_nxt = (dclamp > dmax_r) ? dmax_r : dclamp;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      prop_r   <= PROP_RST;
      integ_r  <= INTEG_RST;
      deriv_r  <= DERIV_RST;
      dmax_r   <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_r <= cfg_wdata[15:0];
        REG_PROP:   prop_r   <= cfg_wdata[15:0];
        REG_INTEG:  integ_r  <= cfg_wdata;
        REG_DERIV:  deriv_r  <= cfg_wdata;
        REG_DMAX:   dmax_r   <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      acc_r       <= '0;
      duty_r      <= DUTY_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_err) begin
        prev_r <= temp_r;
      end
      if (cmd.ld_mul) begin
        acc_r <= acc_nxt;
      end
      if (cmd.commit) begin
        duty_r      <= duty_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.ld_adc) begin
      adc_r <= in_adc_sample;
    end
    if (cmd.ld_temp) begin
      temp_r <= temp_nxt;
    end
    if (cmd.ld_err) begin
      err_r   <= err_nxt;
      dtemp_r <= dtemp_nxt;
    end
    if (cmd.ld_mul) begin
      p_r <= p_nxt;
      d_r <= d_nxt;
    end
    if (cmd.ld_mag) begin
      mag_r     <= mag_nxt;
      acc_neg_r <= acc_r[ACCUM_BITS-1];
    end
    if (cmd.ld_ilo) begin
      ilo_r <= ilo_nxt;
    end
    if (cmd.ld_ihi) begin
      ihi_r <= ihi_nxt;
    end
    if (cmd.ld_isat) begin
      i_r <= i_nxt;
    end
    if (cmd.ld_sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.ld_abs) begin
      smag_r    <= smag_nxt;
      sum_neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.ld_quot) begin
      quot_r <= quot_nxt;
    end
    if (cmd.commit) begin
      out_duty_r <= duty_nxt;
      out_temp_r <= temp_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_duty_value  = out_duty_r;
  assign out_temp_q8     = out_temp_r;

endmodule

>>> hdl/pfd_checker.sv
`timescale 1ns / 1ps

module pfd_assertions (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pfd_pkg::DUTY_W-1:0] out_duty_value,
  input logic [pfd_pkg::TEMP_W-1:0] out_temp_q8
);
  import pfd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_value)
      && $stable(out_temp_q8))
    else $error("result changed while stalled");

  // Only one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Temperature never passes full scale
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_q8 <= TEMP_W'(127968))
    else $error("temperature out of range");

  // Reset leaves no result and an idle input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state after reset wrong");

endmodule

bind pid_fan_duty_controller_top pfd_assertions u_pfd_assertions (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_duty_value (out_duty_value),
  .out_temp_q8    (out_temp_q8)
);

>>> bench/pfd_checker.sv
`timescale 1ns / 1ps

module pfd_checker #(
  parameter int ADC_BITS   = pfd_pkg::ADC_BITS_DEF,
  parameter int ACCUM_BITS = pfd_pkg::ACCUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ADC_BITS-1:0]            in_adc_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pfd_pkg::DUTY_W-1:0]     out_duty_value,
  input  logic [pfd_pkg::TEMP_W-1:0]     out_temp_q8,
  input  logic                           cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import pfd_pkg::*;

  // 500 degrees full scale in Q.8, and the cap on the integral term
  localparam longint FULL_SCALE_Q8 = 128000;
  localparam longint I_CAP         = longint'(1) << 58;
  localparam int     SHOWN_MAX     = 10;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TEMP_W-1:0] temp;
  } fan_result_t;

  fan_result_t       fan_results_q[$];

  // Register copies
  logic [15:0]       target_q8;
  logic [15:0]       kp_q8;
  logic [23:0]       ki_q16;
  logic [23:0]       kd_q8;
  logic [DUTY_W-1:0] duty_ceiling;

  // Controller state
  logic [TEMP_W-1:0] last_temp;
  longint            err_total;
  logic [DUTY_W-1:0] duty_now;

  int                fail_cnt = 0;

  // Saturate the running error sum to the signed accumulator range
  function automatic longint clamp_err_total(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (ACCUM_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Run one PID step on a sample and queue the duty and temperature it gives
  task automatic predict_duty(input logic [ADC_BITS-1:0] adc);
    longint      t;
    longint      err;
    longint      p_term;
    longint      d_term;
    longint      i_mag;
    longint      i_term;
    longint      total;
    longint      mag;
    longint      delta;
    longint      duty;
    fan_result_t res;
    t   = ((longint'(adc) * FULL_SCALE_Q8) >> ADC_BITS) & longint'(17'h1FFFF);
    err = t - longint'(target_q8);
    err_total = clamp_err_total(err_total + err);

    p_term = longint'(kp_q8) * err;
    d_term = longint'(kd_q8) * (t - longint'(last_temp));

    // Integral product on the magnitude, capped, sign restored
    i_mag = (err_total < 0) ? -err_total : err_total;
    if (ki_q16 != 24'd0 && i_mag > I_CAP / longint'(ki_q16)) i_term = I_CAP;
    else i_term = i_mag * longint'(ki_q16);
    if (i_term > I_CAP) i_term = I_CAP;
    if (err_total < 0) i_term = -i_term;

    total = p_term * 256 + i_term + d_term * 256;

    // Scale by five over 2^25 with truncation toward zero
    mag   = (total < 0) ? -total : total;
    mag   = (mag * 5) >> 25;
    delta = (total < 0) ? -mag : mag;

    duty = longint'(duty_now) + delta;
    if (duty < 0) duty = 0;
    if (duty > longint'(duty_ceiling)) duty = longint'(duty_ceiling);

    duty_now  = duty[DUTY_W-1:0];
    last_temp = t[TEMP_W-1:0];
    res.duty  = duty_now;
    res.temp  = last_temp;
    fan_results_q.push_back(res);
  endtask

  always @(posedge clk) begin
    fan_result_t want;
    if (!rst_n) begin
      target_q8    = TARGET_RST;
      kp_q8        = PROP_RST;
      ki_q16       = INTEG_RST;
      kd_q8        = DERIV_RST;
      duty_ceiling = DUTY_MAX_RST;
      last_temp    = '0;
      err_total    = 0;
      duty_now     = DUTY_RST;
      fan_results_q.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: target_q8    = cfg_wdata[15:0];
          REG_PROP:   kp_q8        = cfg_wdata[15:0];
          REG_INTEG:  ki_q16       = cfg_wdata[23:0];
          REG_DERIV:  kd_q8        = cfg_wdata[23:0];
          REG_DMAX:   duty_ceiling = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) predict_duty(in_adc_sample);

      // Compare each result against the oldest prediction
      if (out_valid && out_ready) begin
        if (fan_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= SHOWN_MAX)
            $display("%0t: result with no request pending: duty %0d temp %0d",
                     $realtime, out_duty_value, out_temp_q8);
        end else begin
          want = fan_results_q.pop_front();
          if (want.duty !== out_duty_value || want.temp !== out_temp_q8) begin
            fail_cnt++;
            if (fail_cnt <= SHOWN_MAX)
              $display("%0t: mismatch: duty exp %0d got %0d, temp exp %0d got %0d",
                       $realtime, want.duty, out_duty_value, want.temp, out_temp_q8);
          end
        end
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= fan_results_q.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pfd_pkg::*;

  localparam int ADC_W         = ADC_BITS_DEF;
  localparam int ACC_W         = ACCUM_BITS_DEF;
  localparam int ADC_TOP       = (1 << ADC_W) - 1;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_COUNT   = 9;
  localparam int PHASE_ITEMS   = 58;
  localparam int HOLD_PHASE    = 7;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [ADC_W-1:0]      in_adc_sample = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [DUTY_W-1:0]     out_duty_value;
  logic [TEMP_W-1:0]     out_temp_q8;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  int mismatches;
  int outstanding;
  int snd_idle_pct = 16;
  int rcv_idle_pct = 80;
  int idle_cycles  = 0;
  int walk_lvl     = 164;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  pid_fan_duty_controller_top #(
    .ADC_BITS   (ADC_W),
    .ACCUM_BITS (ACC_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_value (out_duty_value),
    .out_temp_q8    (out_temp_q8),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  pfd_checker #(
    .ADC_BITS   (ADC_W),
    .ACCUM_BITS (ACC_W)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_value (out_duty_value),
    .out_temp_q8    (out_temp_q8),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample after a random gap and hold it until taken
  task automatic send_sample(input logic [ADC_W-1:0] s);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Fill bits above the register width with noise
  function automatic logic [CFG_DATA_W-1:0] pad_word(input int width,
                                                     input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << width) - 1'b1;
    if (width >= CFG_DATA_W) mask = '1;
    return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
  endfunction

  // Write all registers, then a stray write to an unused index
  task automatic program_regs(input logic [15:0] tgt, input logic [15:0] kp,
                              input logic [23:0] ki, input logic [23:0] kd,
                              input logic [DUTY_W-1:0] dmax);
    write_reg(REG_TARGET, pad_word(16, tgt));
    write_reg(REG_PROP, pad_word(16, kp));
    write_reg(REG_INTEG, ki);
    write_reg(REG_DERIV, kd);
    write_reg(REG_DMAX, pad_word(DUTY_W, dmax));
    write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly a slow drift around the working point, with jumps and extremes
  function automatic logic [ADC_W-1:0] next_sample();
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return ADC_W'(ADC_TOP);
    if (pick < 25) return ADC_W'($urandom_range(0, ADC_TOP));
    step = $urandom_range(0, 32);
    walk_lvl = walk_lvl + step - 16;
    if (walk_lvl < 0) walk_lvl = 0;
    if (walk_lvl > ADC_TOP) walk_lvl = ADC_TOP;
    return walk_lvl[ADC_W-1:0];
  endfunction

  initial begin
    int                unsigned at_reset[$];
    int                unsigned at_zero[$];
    int                unsigned at_max[$];
    int                unsigned low_cap[$];
    logic [15:0]       tgt;
    logic [15:0]       kp;
    logic [23:0]       ki;
    logic [23:0]       kd;
    logic [DUTY_W-1:0] dmax;

    at_reset = '{2048, 4095, 0, 1, 4094, 2730, 1365, 164, 164, 165};
    at_zero  = '{4095, 0};
    at_max   = '{0, 4095, 2048, 0, 4095};
    low_cap  = '{164, 164, 165};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults; first sample sees the full temperature as a step
    foreach (at_reset[i]) send_sample(ADC_W'(at_reset[i]));
    drain_results();

    // All gains and the ceiling at zero
    program_regs('0, '0, '0, '0, '0);
    foreach (at_zero[i]) send_sample(ADC_W'(at_zero[i]));
    drain_results();

    // Everything at full scale: duty swings between the clamps
    program_regs('1, '1, '1, '1, '1);
    foreach (at_max[i]) send_sample(ADC_W'(at_max[i]));
    drain_results();

    // Drop the ceiling under a stored duty near the top
    program_regs(TARGET_RST, PROP_RST, '0, '0, 8'd10);
    foreach (low_cap[i]) send_sample(ADC_W'(low_cap[i]));

    // Random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph / 3)
        0: begin
          snd_idle_pct = 16;
          rcv_idle_pct = 80;
        end
        1: begin
          snd_idle_pct = 80;
          rcv_idle_pct = 16;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      drain_results();

      tgt = 16'($urandom_range(0, 65535));
      if (ph % 3 == 2) begin
        kp   = 16'($urandom_range(0, 65535));
        ki   = 24'($urandom_range(0, 24'hFFFFFF));
        kd   = 24'($urandom_range(0, 24'hFFFFFF));
        dmax = DUTY_W'($urandom_range(0, 255));
      end else begin
        kp   = 16'($urandom_range(0, 2047));
        ki   = 24'($urandom_range(0, 2047));
        kd   = 24'($urandom_range(0, 1023));
        dmax = DUTY_W'($urandom_range(40, 255));
      end
      walk_lvl = (int'(tgt) * (ADC_TOP + 1)) / 128000;
      program_regs(tgt, kp, ki, kd, dmax);

      // Stall the receiver while samples keep coming so the block backs up
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(next_sample());
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
